[rtl/rtpc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtpc_pkg
// Shared widths, verdict codes and stage payload types for the ray tube
// point capture test.
// ---------------------------------------------------------------------------
package rtpc_pkg;

   localparam int CoordW    = 32;
   localparam int DiffW     = CoordW + 1;
   localparam int DirW      = 16;
   localparam int LenW      = 31;
   localparam int DistW     = 32;
   localparam int FlagW     = 3;
   localparam int VerdictW  = 3;
   localparam int SqW       = 2 * DiffW;       // sum of two squares
   localparam int RootW     = SqW / 2;         // one root bit per cell
   localparam int RadW      = 2 * RootW;
   localparam int RemW      = RootW + 3;
   localparam int DotW      = DirW + DiffW + 2;
   localparam int SqrtCells = RootW;

   localparam int FLAG_VALID    = 0;
   localparam int FLAG_PREV     = 1;
   localparam int FLAG_DIFFRACT = 2;

   localparam logic [VerdictW-1:0] VERDICT_CAPTURED  = 3'd0;
   localparam logic [VerdictW-1:0] VERDICT_INVALID   = 3'd1;
   localparam logic [VerdictW-1:0] VERDICT_NO_PREV   = 3'd2;
   localparam logic [VerdictW-1:0] VERDICT_DIFFRACT  = 3'd3;
   localparam logic [VerdictW-1:0] VERDICT_OUT_RANGE = 3'd4;
   localparam logic [VerdictW-1:0] VERDICT_OUT_CONE  = 3'd5;

   typedef struct packed {
      logic [VerdictW-1:0]    reject;   // VERDICT_CAPTURED when flags pass
      logic [LenW-1:0]        start;
      logic [LenW-1:0]        lo;
      logic [LenW-1:0]        cur;
      logic signed [DirW-1:0] cc;
      logic signed [DotW-1:0] dot;
   } side_type;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [RadW-1:0]  rad;
   } sqrt_type;

endpackage

[rtl/rtpc_sqrt_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtpc_sqrt_cell
// One digit of the exact integer square root: takes two radicand bits,
// produces one root bit, and hands the word to the next cell.
// ---------------------------------------------------------------------------
module rtpc_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rtpc_pkg::sqrt_type  in_sq,
   input  rtpc_pkg::side_type  in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output rtpc_pkg::sqrt_type  out_sq,
   output rtpc_pkg::side_type  out_side
);
   import rtpc_pkg::*;

   logic               valid_ff;
   sqrt_type           sq_ff, sq_in;
   side_type           side_ff;
   logic [RemW-1:0]    rem_sh, trial;
   logic               take;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rem_sh = {in_sq.rem[RemW-3:0], in_sq.rad[RadW-1 -: 2]};
      trial  = {1'b0, in_sq.root, 2'b01};
      take   = rem_sh >= trial;
      sq_in.rem  = take ? rem_sh - trial : rem_sh;
      sq_in.root = {in_sq.root[RootW-2:0], take};
      sq_in.rad  = {in_sq.rad[RadW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         sq_ff   <= sq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_side  = side_ff;

endmodule

[rtl/ray_tube_point_capture_test_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_tube_point_capture_test_unit
// Tests whether a receiver point lies inside a 2D ray tube: flag checks,
// exact distance to the virtual source, path window and cone test.
//
//   channel | ports              | role
//   --------+--------------------+---------------------------------
//   request | req_valid/req_stall| point, tube and node words in
//   result  | rsp_valid/rsp_stall| captured, verdict, path_distance
//   config  | csr_we/csr_wdata   | split_radius
//
// One word per cycle while rsp_stall is low. Stages: differences, squares,
// sums, a row of 33 square root cells (one root bit each), bound, output.
// Every stage holds its word until the next one frees up, so bubbles
// collapse and input is taken while a result waits on a stalled output.
// Synchronous reset clears the valid bits and split_radius.
// ---------------------------------------------------------------------------
module ray_tube_point_capture_test_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rtpc_pkg::CoordW-1:0]   req_point_x,
   input  logic signed [rtpc_pkg::CoordW-1:0]   req_point_y,
   input  logic signed [rtpc_pkg::CoordW-1:0]   req_source_x,
   input  logic signed [rtpc_pkg::CoordW-1:0]   req_source_y,
   input  logic signed [rtpc_pkg::DirW-1:0]     req_dir_x,
   input  logic signed [rtpc_pkg::DirW-1:0]     req_dir_y,
   input  logic signed [rtpc_pkg::DirW-1:0]     req_cone_cos,
   input  logic [rtpc_pkg::LenW-1:0]            req_start_offset,
   input  logic [rtpc_pkg::LenW-1:0]            req_prev_length,
   input  logic [rtpc_pkg::LenW-1:0]            req_cur_length,
   input  logic [rtpc_pkg::FlagW-1:0]           req_node_flags,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_captured,
   output logic [rtpc_pkg::VerdictW-1:0]        rsp_verdict,
   output logic [rtpc_pkg::DistW-1:0]           rsp_path_distance,
   input  logic                                 csr_we,
   input  logic [rtpc_pkg::LenW-1:0]            csr_wdata
);
   import rtpc_pkg::*;

   logic [LenW-1:0] split_ff;

   // stage 1: differences, flag decode
   logic                    v1_ff, r1;
   logic signed [DiffW-1:0] dx1_ff, dy1_ff;
   logic signed [DirW-1:0]  dirx1_ff, diry1_ff;
   side_type                side1_ff, side1_in;
   // stage 2: squares and direction products
   logic                    v2_ff, r2;
   logic [SqW-1:0]          sqx2_ff, sqy2_ff;
   logic signed [DirW+DiffW-1:0] dotx2_ff, doty2_ff;
   side_type                side2_ff;
   logic [DiffW-1:0]        ax1, ay1;
   // stage 3: sums
   logic                    v3_ff, r3;
   logic [SqW-1:0]          sq3_ff;
   side_type                side3_ff, side3_in;
   // cell row
   logic                    cv  [SqrtCells+1];
   logic                    cr  [SqrtCells+1];
   sqrt_type                csq [SqrtCells+1];
   side_type                cs  [SqrtCells+1];
   // stage 4: t and cone bound
   logic                    v4_ff, r4;
   logic [DistW-1:0]        t4_ff;
   logic signed [DotW-1:0]  rhs4_ff;
   side_type                side4_ff;
   logic [RootW:0]          tsum;
   logic [DistW-1:0]        tsat;
   // stage 5: output
   logic                    v5_ff, r5;
   logic                    cap5_ff;
   logic [VerdictW-1:0]     ver5_ff, ver5_in;
   logic [DistW-1:0]        dist5_ff, dist5_in;
   logic [DistW-1:0]        hi_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= '0;
      end else if (csr_we) begin
         split_ff <= csr_wdata;
      end
   end

   assign r5 = !v5_ff || !rsp_stall;
   assign r4 = !v4_ff || r5;
   assign cr[SqrtCells] = r4;
   assign r3 = cr[0];
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign req_stall = !r1;

   // flags are tested in order valid, previous present, diffraction
   always_comb begin
      side1_in.start = req_start_offset;
      side1_in.lo    = req_prev_length;
      side1_in.cur   = req_cur_length;
      side1_in.cc    = req_cone_cos;
      side1_in.dot   = '0;
      if (!req_node_flags[FLAG_VALID]) begin
         side1_in.reject = VERDICT_INVALID;
      end else if (!req_node_flags[FLAG_PREV]) begin
         side1_in.reject = VERDICT_NO_PREV;
      end else if (req_node_flags[FLAG_DIFFRACT]) begin
         side1_in.reject = VERDICT_DIFFRACT;
      end else begin
         side1_in.reject = VERDICT_CAPTURED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (r1) begin
         v1_ff <= req_valid;
      end
      if (r1 && req_valid) begin
         dx1_ff   <= DiffW'(req_point_x) - DiffW'(req_source_x);
         dy1_ff   <= DiffW'(req_point_y) - DiffW'(req_source_y);
         dirx1_ff <= req_dir_x;
         diry1_ff <= req_dir_y;
         side1_ff <= side1_in;
      end
   end

   assign ax1 = dx1_ff[DiffW-1] ? DiffW'(-dx1_ff) : DiffW'(dx1_ff);
   assign ay1 = dy1_ff[DiffW-1] ? DiffW'(-dy1_ff) : DiffW'(dy1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (r2) begin
         v2_ff <= v1_ff;
      end
      if (r2 && v1_ff) begin
         sqx2_ff  <= ax1 * ax1;
         sqy2_ff  <= ay1 * ay1;
         dotx2_ff <= dirx1_ff * dx1_ff;
         doty2_ff <= diry1_ff * dy1_ff;
         side2_ff <= side1_ff;
      end
   end

   always_comb begin
      side3_in     = side2_ff;
      side3_in.dot = DotW'(dotx2_ff) + DotW'(doty2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (r3) begin
         v3_ff <= v2_ff;
      end
      if (r3 && v2_ff) begin
         sq3_ff   <= sqx2_ff + sqy2_ff;
         side3_ff <= side3_in;
      end
   end

   assign cv[0]       = v3_ff;
   assign csq[0].rem  = '0;
   assign csq[0].root = '0;
   assign csq[0].rad  = RadW'(sq3_ff);
   assign cs[0]       = side3_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_cell
      rtpc_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_sq     (csq[i]),
         .in_side   (cs[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_sq    (csq[i+1]),
         .out_side  (cs[i+1])
      );
   end

   assign tsum = (RootW+1)'(csq[SqrtCells].root) + (RootW+1)'(cs[SqrtCells].start);
   assign tsat = (tsum[RootW:DistW] != '0) ? '1 : tsum[DistW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (r4) begin
         v4_ff <= cv[SqrtCells];
      end
      if (r4 && cv[SqrtCells]) begin
         t4_ff    <= tsat;
         rhs4_ff  <= DotW'(cs[SqrtCells].cc)
                     * DotW'($signed({1'b0, csq[SqrtCells].root}));
         side4_ff <= cs[SqrtCells];
      end
   end

   assign hi_b = DistW'(side4_ff.cur) + DistW'(split_ff);

   always_comb begin
      dist5_in = t4_ff;
      if (side4_ff.reject != VERDICT_CAPTURED) begin
         ver5_in  = side4_ff.reject;
         dist5_in = '0;
      end else if (t4_ff > hi_b || t4_ff < DistW'(side4_ff.lo)) begin
         ver5_in = VERDICT_OUT_RANGE;
      end else if (side4_ff.dot < rhs4_ff) begin
         ver5_in = VERDICT_OUT_CONE;
      end else begin
         ver5_in = VERDICT_CAPTURED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (r5) begin
         v5_ff <= v4_ff;
      end
      if (r5 && v4_ff) begin
         ver5_ff  <= ver5_in;
         cap5_ff  <= ver5_in == VERDICT_CAPTURED;
         dist5_ff <= dist5_in;
      end
   end

   assign rsp_valid         = v5_ff;
   assign rsp_captured      = cap5_ff;
   assign rsp_verdict       = ver5_ff;
   assign rsp_path_distance = dist5_ff;

endmodule
